// ===== design/kmeans_assign_and_cluster_stats_macros.svh =====
// ----------------------------------------------------------------------------
// kmeans_assign_and_cluster_stats_macros.svh
// Assertion macros used by the k-means block checks.
// ----------------------------------------------------------------------------
`ifndef KMEANS_ASSIGN_AND_CLUSTER_STATS_MACROS_SVH
`define KMEANS_ASSIGN_AND_CLUSTER_STATS_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KMACS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmacs check failed");

// next-cycle implication
`define KMACS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmacs check failed");

`endif

// ===== design/kmacs_pkg.sv =====
// ----------------------------------------------------------------------------
// kmacs_pkg
// Types, codes and defaults of the k-means assignment and statistics block.
// ----------------------------------------------------------------------------
package kmacs_pkg;

	localparam int MAX_CLUSTERS_DEF = 8;
	localparam int MAX_DIMS_DEF     = 8;
	localparam int COUNT_BITS_DEF   = 24;

	// width that holds any active cluster or element limit
	localparam int LIM_W = 8;

	localparam logic [34:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SAMPLE,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		KIND_ASSIGN,
		KIND_STATS,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_RANGE,
		STAT_EMPTY,
		STAT_SAT
	} status_t;

	typedef enum logic [0:0] {
		REG_MEANS,
		REG_DIMS
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST,
		ST_CHECK,
		ST_ACC,
		ST_RD,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_W_GO,
		ST_W_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t                operation;
		logic [2:0]         cluster_index;
		logic [2:0]         element_index;
		logic signed [15:0] value;
	} req_t;

	typedef struct packed {
		kind_t              result_kind;
		logic [2:0]         closest_cluster;
		logic [34:0]        min_distance;
		logic signed [15:0] mean_out;
		logic [30:0]        variance_out;
		logic [16:0]        weight_out;
		logic [23:0]        count_out;
		status_t            status_flag;
	} rsp_t;

endpackage

// ===== design/kmacs_div.sv =====
// ----------------------------------------------------------------------------
// kmacs_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmacs_div #(
	parameter int DVD_W = 57,
	parameter int DVS_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// shift the dividend out and the quotient in through one register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/kmeans_assign_and_cluster_stats.sv =====
// ----------------------------------------------------------------------------
// kmeans_assign_and_cluster_stats
// Nearest-centroid assignment with per-cluster sum, square sum and count.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_stall is high while a request is in
// work. Loads, non-final sample elements and clears complete in the idle
// state; a range error posts its result from the emit state. The final
// sample element walks the centroid memory one element per cycle through a
// read, multiply and accumulate pipeline, then a read-modify-write pass runs
// on the sum and square-sum memories. A statistics read runs three divisions
// on the bit-serial divider, one quotient bit per cycle; its divisor is as
// wide as the counts, 24 bits by default. Statistics entries carry valid
// bits, so reset and clear take effect at once and there is no clearing
// pass. A finished result sits in the output register while the next
// request is accepted. Centroid and sample entries must be written before
// use.
// ----------------------------------------------------------------------------
module kmeans_assign_and_cluster_stats #(
	parameter int MAX_CLUSTERS = kmacs_pkg::MAX_CLUSTERS_DEF,
	parameter int MAX_DIMS     = kmacs_pkg::MAX_DIMS_DEF,
	parameter int COUNT_BITS   = kmacs_pkg::COUNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [3:0]      cfg_data,
	input  logic            req_valid,
	output logic            req_stall,
	input  kmacs_pkg::req_t req_data,
	output logic            res_valid,
	input  logic            res_stall,
	output kmacs_pkg::rsp_t res_data
);

	localparam int NENT  = MAX_CLUSTERS * MAX_DIMS;
	localparam int AW    = (NENT > 1) ? $clog2(NENT) : 1;
	localparam int CIW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int EIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DVD_W = (COUNT_BITS + 17 > 57) ? COUNT_BITS + 17 : 57;
	localparam int LW    = kmacs_pkg::LIM_W;

	// map (cluster, element) to a flat statistics or centroid address
	function automatic logic [AW-1:0] ent_addr(input logic [CIW-1:0] c,
		input logic [EIW-1:0] e);
		ent_addr = AW'(int'(c) * MAX_DIMS + int'(e));
	endfunction

	// clamp a count to the 24-bit output field
	function automatic logic [23:0] cap24(input logic [COUNT_BITS-1:0] n);
		cap24 = (32'(n) > 32'hFF_FFFF) ? 24'hFF_FFFF : 24'(n);
	endfunction

	// ---------------------------------------------------------------- state
	kmacs_pkg::state_t state_q, state_d;

	logic [3:0] means_q, dims_q;
	logic [LW-1:0] nm, nd;

	logic [COUNT_BITS-1:0] count_q [MAX_CLUSTERS];
	logic [COUNT_BITS-1:0] total_q;
	logic [NENT-1:0]       vld_q;

	// centroid, sum and square-sum memories
	logic signed [15:0] cent_mem [NENT];
	logic signed [39:0] sum_mem  [NENT];
	logic [55:0]        sq_mem   [NENT];
	logic signed [15:0] samp_buf [MAX_DIMS];

	// walk counters and best match
	logic [CIW-1:0] c_q, best_q;
	logic [EIW-1:0] e_q;
	logic           iss_done_q;
	logic [34:0]    dacc_q, best_d_q;

	// pipeline: stage 1 holds memory reads, stage 2 the product
	logic               v_s1, v_s2;
	logic               last_e_s1, last_e_s2;
	logic               last_all_s1, last_all_s2;
	logic [CIW-1:0]     clu_s1, clu_s2;
	logic [AW-1:0]      addr_s1, addr_s2;
	logic signed [15:0] samp_s1, cent_rd_s1;
	logic signed [39:0] sum_rd_s1;
	logic [55:0]        sq_rd_s1, sq_base_s2;
	logic               vldr_s1;
	logic signed [33:0] prod_s2;

	// statistics read results
	logic [15:0]      qm_q;
	logic [DVD_W-1:0] msq_q;

	kmacs_pkg::rsp_t res_q, res_data_q;
	logic            res_valid_q;

	// ------------------------------------------------------------ comb decode
	logic                  req_acc, c_ok, e_ok, e_last_req;
	logic                  issuing, e_last_q, c_last_q;
	logic                  dist_fin, acc_fin, sat, emit_go;
	logic                  cent_we, samp_we, sum_we, sq_we, div_start;
	logic [AW-1:0]         rd_addr, req_addr;
	logic signed [16:0]    mul_op;
	logic signed [33:0]    mul_res;
	logic [33:0]           prod_u;
	logic [35:0]           dsum;
	logic [34:0]           dsat;
	logic signed [39:0]    s_val, sum_new;
	logic [39:0]           s_mag;
	logic [55:0]           sq_val;
	logic [COUNT_BITS-1:0] n_rd;
	logic [DVD_W-1:0]      div_dvd, div_quo, var_full;
	logic [COUNT_BITS-1:0] div_dvs;
	logic                  div_done;

	// 0 acts as 1, values above the maximum act as the maximum
	assign nm = (means_q == '0) ? LW'(1) :
		((LW'(means_q) > LW'(MAX_CLUSTERS)) ? LW'(MAX_CLUSTERS) : LW'(means_q));
	assign nd = (dims_q == '0) ? LW'(1) :
		((LW'(dims_q) > LW'(MAX_DIMS)) ? LW'(MAX_DIMS) : LW'(dims_q));

	assign req_acc    = req_valid && !req_stall;
	assign c_ok       = LW'(req_data.cluster_index) < nm;
	assign e_ok       = LW'(req_data.element_index) < nd;
	assign e_last_req = LW'(req_data.element_index) + LW'(1) == nd;
	assign req_addr   = ent_addr(CIW'(req_data.cluster_index),
		EIW'(req_data.element_index));

	assign e_last_q = LW'(e_q) + LW'(1) == nd;
	assign c_last_q = LW'(c_q) + LW'(1) == nm;
	assign rd_addr  = ent_addr((state_q == kmacs_pkg::ST_ACC) ? best_q : c_q, e_q);

	assign dist_fin = (state_q == kmacs_pkg::ST_DIST) && v_s2 && last_all_s2;
	assign acc_fin  = (state_q == kmacs_pkg::ST_ACC) && v_s2 && last_all_s2;
	assign sat      = total_q == '1;
	assign emit_go  = (state_q == kmacs_pkg::ST_EMIT) && (!res_valid_q || !res_stall);

	// shared squarer: distance term, sample square or squared mean
	always_comb begin
		case (state_q)
			kmacs_pkg::ST_DIST: mul_op = 17'(cent_rd_s1) - 17'(samp_s1);
			kmacs_pkg::ST_ACC:  mul_op = 17'(samp_s1);
			default:            mul_op = $signed({1'b0, qm_q});
		endcase
	end
	assign mul_res = mul_op * mul_op;
	assign prod_u  = prod_s2;

	// saturating distance accumulate
	assign dsum = {1'b0, dacc_q} + 36'(prod_u);
	assign dsat = (dsum > 36'(kmacs_pkg::DIST_MAX)) ? kmacs_pkg::DIST_MAX : dsum[34:0];

	// unwritten statistics entries read as zero
	assign s_val   = vldr_s1 ? sum_rd_s1 : '0;
	assign sq_val  = vldr_s1 ? sq_rd_s1 : '0;
	assign s_mag   = s_val[39] ? 40'(-s_val) : 40'(s_val);
	assign sum_new = s_val + 40'(samp_s1);
	assign n_rd    = count_q[c_q];

	always_comb begin
		case (state_q)
			kmacs_pkg::ST_SQ_GO: begin
				div_dvd = DVD_W'(sq_val) + DVD_W'(n_rd >> 1);
				div_dvs = n_rd;
			end
			kmacs_pkg::ST_W_GO: begin
				div_dvd = (DVD_W'(n_rd) << 16) + DVD_W'(total_q >> 1);
				div_dvs = total_q;
			end
			default: begin
				div_dvd = DVD_W'(s_mag) + DVD_W'(n_rd >> 1);
				div_dvs = n_rd;
			end
		endcase
	end

	assign var_full = (msq_q > DVD_W'(prod_u)) ? msq_q - DVD_W'(prod_u) : '0;

	kmacs_div #(
		.DVD_W(DVD_W),
		.DVS_W(COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quo)
	);

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kmacs_pkg::ST_IDLE: begin
				if (req_acc) begin
					case (req_data.operation)
						kmacs_pkg::OP_LOAD: begin
							if (!(c_ok && e_ok)) state_d = kmacs_pkg::ST_EMIT;
						end
						kmacs_pkg::OP_SAMPLE: begin
							if (!e_ok) state_d = kmacs_pkg::ST_EMIT;
							else if (e_last_req) state_d = kmacs_pkg::ST_DIST;
						end
						kmacs_pkg::OP_CLEAR: state_d = kmacs_pkg::ST_IDLE;
						kmacs_pkg::OP_READ: begin
							state_d = (c_ok && e_ok) ? kmacs_pkg::ST_RD : kmacs_pkg::ST_EMIT;
						end
						default: state_d = kmacs_pkg::ST_IDLE;
					endcase
				end
			end
			kmacs_pkg::ST_DIST:  if (dist_fin) state_d = kmacs_pkg::ST_CHECK;
			kmacs_pkg::ST_CHECK: state_d = sat ? kmacs_pkg::ST_EMIT : kmacs_pkg::ST_ACC;
			kmacs_pkg::ST_ACC:   if (acc_fin) state_d = kmacs_pkg::ST_EMIT;
			kmacs_pkg::ST_RD: begin
				state_d = (n_rd == '0) ? kmacs_pkg::ST_EMIT : kmacs_pkg::ST_MEAN_GO;
			end
			kmacs_pkg::ST_MEAN_GO:   state_d = kmacs_pkg::ST_MEAN_WAIT;
			kmacs_pkg::ST_MEAN_WAIT: if (div_done) state_d = kmacs_pkg::ST_SQ_GO;
			kmacs_pkg::ST_SQ_GO:     state_d = kmacs_pkg::ST_SQ_WAIT;
			kmacs_pkg::ST_SQ_WAIT:   if (div_done) state_d = kmacs_pkg::ST_W_GO;
			kmacs_pkg::ST_W_GO:      state_d = kmacs_pkg::ST_W_WAIT;
			kmacs_pkg::ST_W_WAIT:    if (div_done) state_d = kmacs_pkg::ST_EMIT;
			kmacs_pkg::ST_EMIT:      if (emit_go) state_d = kmacs_pkg::ST_IDLE;
			default:                 state_d = kmacs_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------ state outputs
	always_comb begin
		req_stall = state_q != kmacs_pkg::ST_IDLE;
		issuing   = ((state_q == kmacs_pkg::ST_DIST) || (state_q == kmacs_pkg::ST_ACC))
			&& !iss_done_q;
		div_start = (state_q == kmacs_pkg::ST_MEAN_GO) || (state_q == kmacs_pkg::ST_SQ_GO)
			|| (state_q == kmacs_pkg::ST_W_GO);
		cent_we   = (state_q == kmacs_pkg::ST_IDLE) && req_acc
			&& (req_data.operation == kmacs_pkg::OP_LOAD) && c_ok && e_ok;
		samp_we   = (state_q == kmacs_pkg::ST_IDLE) && req_acc
			&& (req_data.operation == kmacs_pkg::OP_SAMPLE) && e_ok;
		sum_we    = (state_q == kmacs_pkg::ST_ACC) && v_s1;
		sq_we     = (state_q == kmacs_pkg::ST_ACC) && v_s2;
	end

	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------ control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kmacs_pkg::ST_IDLE;
			means_q     <= 4'd8;
			dims_q      <= 4'd8;
			total_q     <= '0;
			vld_q       <= '0;
			iss_done_q  <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			v_s1    <= issuing;
			v_s2    <= v_s1;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kmacs_pkg::REG_MEANS: means_q <= cfg_data;
					kmacs_pkg::REG_DIMS:  dims_q  <= cfg_data;
					default:              means_q <= means_q;
				endcase
			end

			// clear statistics: drop every valid bit and every count
			if (req_acc && (req_data.operation == kmacs_pkg::OP_CLEAR)) begin
				vld_q   <= '0;
				total_q <= '0;
				for (int i = 0; i < MAX_CLUSTERS; i++) begin
					count_q[i] <= '0;
				end
			end

			if (sq_we) vld_q[addr_s2] <= 1'b1;
			if (acc_fin) begin
				count_q[best_q] <= count_q[best_q] + 1'b1;
				total_q         <= total_q + 1'b1;
			end

			// issue bookkeeping for both walks
			case (state_q)
				kmacs_pkg::ST_IDLE:  iss_done_q <= 1'b0;
				kmacs_pkg::ST_CHECK: iss_done_q <= 1'b0;
				kmacs_pkg::ST_DIST: begin
					if (issuing && e_last_q && c_last_q) iss_done_q <= 1'b1;
				end
				kmacs_pkg::ST_ACC: begin
					if (issuing && e_last_q) iss_done_q <= 1'b1;
				end
				default: iss_done_q <= iss_done_q;
			endcase

			// output register: free on take, load from the pending result
			if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			if (emit_go) res_valid_q <= 1'b1;
		end
	end

	// ------------------------------------------------------------ memories
	always_ff @(posedge clk) begin
		if (cent_we) cent_mem[req_addr] <= req_data.value;
		cent_rd_s1 <= cent_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[addr_s1] <= sum_new;
		sum_rd_s1 <= sum_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sq_we) sq_mem[addr_s2] <= sq_base_s2 + 56'(prod_u);
		sq_rd_s1 <= sq_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (samp_we) samp_buf[EIW'(req_data.element_index)] <= req_data.value;
	end

	// ------------------------------------------------------------ datapath
	always_ff @(posedge clk) begin
		// stage 1: operands beside the memory reads
		samp_s1     <= samp_buf[e_q];
		vldr_s1     <= vld_q[rd_addr];
		addr_s1     <= rd_addr;
		clu_s1      <= c_q;
		last_e_s1   <= e_last_q;
		last_all_s1 <= (state_q == kmacs_pkg::ST_ACC) ? e_last_q : (e_last_q && c_last_q);

		// stage 2: product and carried tags
		prod_s2     <= mul_res;
		sq_base_s2  <= sq_val;
		addr_s2     <= addr_s1;
		clu_s2      <= clu_s1;
		last_e_s2   <= last_e_s1;
		last_all_s2 <= last_all_s1;

		case (state_q)
			kmacs_pkg::ST_IDLE: begin
				if (req_acc) begin
					if (req_data.operation == kmacs_pkg::OP_SAMPLE) begin
						c_q    <= '0;
						e_q    <= '0;
						dacc_q <= '0;
					end else begin
						c_q <= CIW'(req_data.cluster_index);
						e_q <= EIW'(req_data.element_index);
					end
					res_q             <= '0;
					res_q.result_kind <= kmacs_pkg::KIND_ERROR;
					res_q.status_flag <= kmacs_pkg::STAT_RANGE;
				end
			end
			kmacs_pkg::ST_DIST: begin
				if (issuing) begin
					if (e_last_q) begin
						e_q <= '0;
						if (!c_last_q) c_q <= CIW'(c_q + 1'b1);
					end else begin
						e_q <= EIW'(e_q + 1'b1);
					end
				end
				// close a cluster: keep the strictly smaller distance
				if (v_s2) begin
					if (last_e_s2) begin
						if ((clu_s2 == '0) || (dsat < best_d_q)) begin
							best_d_q <= dsat;
							best_q   <= clu_s2;
						end
						dacc_q <= '0;
					end else begin
						dacc_q <= dsat;
					end
				end
			end
			kmacs_pkg::ST_CHECK: begin
				e_q                   <= '0;
				res_q                 <= '0;
				res_q.result_kind     <= kmacs_pkg::KIND_ASSIGN;
				res_q.closest_cluster <= 3'(best_q);
				res_q.min_distance    <= best_d_q;
				res_q.count_out       <= cap24(count_q[best_q]);
				res_q.status_flag     <= kmacs_pkg::STAT_SAT;
			end
			kmacs_pkg::ST_ACC: begin
				if (issuing && !e_last_q) e_q <= EIW'(e_q + 1'b1);
				if (acc_fin) begin
					res_q.count_out   <= cap24(COUNT_BITS'(count_q[best_q] + 1'b1));
					res_q.status_flag <= kmacs_pkg::STAT_OK;
				end
			end
			kmacs_pkg::ST_RD: begin
				res_q             <= '0;
				res_q.result_kind <= kmacs_pkg::KIND_STATS;
				res_q.status_flag <= kmacs_pkg::STAT_EMPTY;
			end
			kmacs_pkg::ST_MEAN_WAIT: if (div_done) qm_q <= div_quo[15:0];
			kmacs_pkg::ST_SQ_WAIT:   if (div_done) msq_q <= div_quo;
			kmacs_pkg::ST_W_WAIT: begin
				// prod_s2 holds the squared mean by now
				if (div_done) begin
					res_q.mean_out     <= s_val[39] ? -$signed(qm_q) : $signed(qm_q);
					res_q.variance_out <= 31'(var_full);
					res_q.weight_out   <= (total_q == '0) ? '0 : div_quo[16:0];
					res_q.count_out    <= cap24(n_rd);
					res_q.status_flag  <= sat ? kmacs_pkg::STAT_SAT : kmacs_pkg::STAT_OK;
				end
			end
			default: res_q <= res_q;
		endcase

		if (emit_go) res_data_q <= res_q;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

// ===== design/kmacs_chk.sv =====
// ----------------------------------------------------------------------------
// kmacs_chk
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "kmeans_assign_and_cluster_stats_macros.svh"

module kmacs_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_stall,
	input kmacs_pkg::rsp_t res_data
);

	`KMACS_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(res_data))

	`KMACS_ASSERT_NOW(a_error_shape, res_valid && (res_data.result_kind == kmacs_pkg::KIND_ERROR), (res_data.status_flag == kmacs_pkg::STAT_RANGE) && (res_data.count_out == '0) && (res_data.min_distance == '0))

	`KMACS_ASSERT_NOW(a_empty_zero, res_valid && (res_data.result_kind == kmacs_pkg::KIND_STATS) && (res_data.status_flag == kmacs_pkg::STAT_EMPTY), (res_data.mean_out == '0) && (res_data.variance_out == '0) && (res_data.weight_out == '0) && (res_data.count_out == '0))

	`KMACS_ASSERT_NOW(a_assign_shape, res_valid && (res_data.result_kind == kmacs_pkg::KIND_ASSIGN), (res_data.mean_out == '0) && (res_data.weight_out == '0) && (res_data.status_flag != kmacs_pkg::STAT_RANGE) && (res_data.status_flag != kmacs_pkg::STAT_EMPTY))

endmodule

bind kmeans_assign_and_cluster_stats kmacs_chk u_kmacs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

// ===== tb/sv/kmacs_checker.sv =====
// ----------------------------------------------------------------------------
// kmacs_checker
// Watches the configuration, request and result channels of the k-means
// block. Keeps its own copy of the centroid table and cluster statistics,
// predicts the result, if any, of each accepted request and compares every
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module kmacs_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [3:0]       cfg_data,
	input  logic             req_valid,
	input  logic             req_stall,
	input  kmacs_pkg::req_t  req_data,
	input  logic             res_valid,
	input  logic             res_stall,
	input  kmacs_pkg::rsp_t  res_data,
	output int               fail_count,
	output int               pending
);
	import kmacs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned DIST_CAP  = 64'h7_FFFF_FFFF;
	localparam longint unsigned COUNT_CAP = 64'hFF_FFFF;

	logic [3:0]      means_reg;
	logic [3:0]      dims_reg;
	longint          centroid_tab [64];
	longint          sample_buf [8];
	longint          sum_tab [64];
	longint unsigned sq_sum_tab [64];
	longint unsigned count_tab [8];
	longint unsigned total_samples;
	rsp_t            expected_results [$];

	function automatic int clamp_limit(input logic [3:0] r);
		if (r == 0) return 1;
		if (r > 8) return 8;
		return int'(r);
	endfunction

	task automatic clear_statistics();
		for (int i = 0; i < 64; i++) begin
			sum_tab[i] = 0;
			sq_sum_tab[i] = 0;
		end
		for (int i = 0; i < 8; i++) count_tab[i] = 0;
		total_samples = 0;
	endtask

	task automatic nearest_centroid(input int nm, input int nd, output rsp_t o);
		longint unsigned best_d;
		longint unsigned d;
		longint          diff;
		int              best;
		best = 0;
		best_d = 0;
		o = '0;
		for (int c = 0; c < nm; c++) begin
			d = 0;
			for (int e = 0; e < nd; e++) begin
				diff = centroid_tab[c*8+e] - sample_buf[e];
				d += longint'(diff * diff);
				if (d > DIST_CAP) d = DIST_CAP;
			end
			if (c == 0 || d < best_d) begin
				best_d = d;
				best = c;
			end
		end
		o.result_kind = KIND_ASSIGN;
		o.status_flag = STAT_OK;
		if (total_samples >= COUNT_CAP) begin
			o.status_flag = STAT_SAT;
		end else begin
			for (int e = 0; e < nd; e++) begin
				sum_tab[best*8+e] += sample_buf[e];
				sq_sum_tab[best*8+e] += longint'(sample_buf[e] * sample_buf[e]);
			end
			count_tab[best]++;
			total_samples++;
		end
		o.closest_cluster = 3'(best);
		o.min_distance = 35'(best_d);
		o.count_out = 24'((count_tab[best] > COUNT_CAP) ? COUNT_CAP : count_tab[best]);
	endtask

	task automatic cluster_stats(input int c, input int e, output rsp_t o);
		longint unsigned n, mag, qm, msq, var_v, w;
		longint          s, mean;
		o = '0;
		o.result_kind = KIND_STATS;
		n = count_tab[c];
		if (n == 0) begin
			o.status_flag = STAT_EMPTY;
		end else begin
			s = sum_tab[c*8+e];
			mag = (s < 0) ? longint'(-s) : longint'(s);
			qm = (mag + n / 2) / n;
			mean = (s < 0) ? -longint'(qm) : longint'(qm);
			msq = (sq_sum_tab[c*8+e] + n / 2) / n;
			var_v = (msq > qm * qm) ? msq - qm * qm : 0;
			w = (total_samples == 0) ? 0 : ((n << 16) + total_samples / 2) / total_samples;
			o.mean_out = 16'(mean);
			o.variance_out = 31'(var_v);
			o.weight_out = 17'(w);
			o.count_out = 24'((n > COUNT_CAP) ? COUNT_CAP : n);
			o.status_flag = (total_samples >= COUNT_CAP) ? STAT_SAT : STAT_OK;
		end
	endtask

	task automatic predict_request(input req_t r);
		int   nm, nd, c, e;
		rsp_t o;
		bit   has_result;
		nm = clamp_limit(means_reg);
		nd = clamp_limit(dims_reg);
		c = int'(r.cluster_index);
		e = int'(r.element_index);
		o = '0;
		o.result_kind = KIND_ERROR;
		o.status_flag = STAT_RANGE;
		has_result = 0;
		case (r.operation)
			OP_LOAD: begin
				if (c >= nm || e >= nd) has_result = 1;
				else centroid_tab[c*8+e] = longint'(r.value);
			end
			OP_SAMPLE: begin
				if (e >= nd) begin
					has_result = 1;
				end else begin
					sample_buf[e] = longint'(r.value);
					if (e + 1 == nd) begin
						nearest_centroid(nm, nd, o);
						has_result = 1;
					end
				end
			end
			OP_CLEAR: clear_statistics();
			default: begin
				has_result = 1;
				if (c < nm && e < nd) cluster_stats(c, e, o);
			end
		endcase
		if (has_result) expected_results.push_back(o);
	endtask

	task automatic report_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	task automatic compare_result(input rsp_t got);
		rsp_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result", longint'(got.result_kind), 0);
		end else begin
			want = expected_results.pop_front();
			if (got.result_kind !== want.result_kind)
				report_mismatch("result_kind", got.result_kind, want.result_kind);
			if (got.closest_cluster !== want.closest_cluster)
				report_mismatch("closest_cluster", got.closest_cluster, want.closest_cluster);
			if (got.min_distance !== want.min_distance)
				report_mismatch("min_distance", got.min_distance, want.min_distance);
			if (got.mean_out !== want.mean_out)
				report_mismatch("mean_out", 16'(got.mean_out), 16'(want.mean_out));
			if (got.variance_out !== want.variance_out)
				report_mismatch("variance_out", got.variance_out, want.variance_out);
			if (got.weight_out !== want.weight_out)
				report_mismatch("weight_out", got.weight_out, want.weight_out);
			if (got.count_out !== want.count_out)
				report_mismatch("count_out", got.count_out, want.count_out);
			if (got.status_flag !== want.status_flag)
				report_mismatch("status_flag", got.status_flag, want.status_flag);
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			means_reg = 4'd8;
			dims_reg = 4'd8;
			for (int i = 0; i < 64; i++) centroid_tab[i] = 0;
			for (int i = 0; i < 8; i++) sample_buf[i] = 0;
			clear_statistics();
			expected_results.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MEANS) means_reg = cfg_data;
				else dims_reg = cfg_data;
			end
			if (req_valid && !req_stall) predict_request(req_data);
			if (res_valid && !res_stall) compare_result(res_data);
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the k-means block: loads the centroid table, runs a directed pass
// over the corner cases, then random requests under several register
// settings with random gaps and result back-pressure. The checker beside
// the block predicts and compares; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import kmacs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// a statistics read runs three serial divisions, so settle generously
	localparam int SETTLE_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [3:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	rsp_t res_data;
	int fail_count;
	int pending;

	// effective limits of the current setting, as the stimulus sees them
	int cur_means = 8;
	int cur_dims = 8;

	kmeans_assign_and_cluster_stats u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	kmacs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result back-pressure: mostly short stalls, a few long ones, and now
	// and then a long stretch with no stall at all.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					res_stall <= 1'b1;
					stall_left <= $urandom_range(30, 90);
				end
				1: begin
					res_stall <= 1'b0;
					stall_left <= $urandom_range(100, 300);
				end
				2, 3, 4, 5: begin
					res_stall <= 1'b1;
					stall_left <= $urandom_range(0, 3);
				end
				default: begin
					res_stall <= 1'b0;
					stall_left <= $urandom_range(0, 4);
				end
			endcase
		end
	end

	function automatic int clamp_limit(input int r);
		if (r == 0) return 1;
		if (r > 8) return 8;
		return r;
	endfunction

	function automatic logic [15:0] pick_value();
		int offset;
		offset = int'($urandom_range(0, 8)) - 4;
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'(offset);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_request(input op_t op, input int c, input int e, input logic [15:0] v);
		@(negedge clk);
		req_valid <= 1'b1;
		req_data.operation <= op;
		req_data.cluster_index <= 3'(c);
		req_data.element_index <= 3'(e);
		req_data.value <= v;
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid for a number of cycles; a zero gap keeps requests back to back.
	task automatic idle_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Hold off until every predicted result is in, then let the block drain.
	task automatic drain_block();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input int means, input int dims);
		drain_block();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MEANS;
		cfg_data <= 4'(means);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_DIMS;
		cfg_data <= 4'(dims);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_means = clamp_limit(means);
		cur_dims = clamp_limit(dims);
	endtask

	// Random traffic: mostly whole samples, plus loads, reads, clears and
	// stray sample elements.
	task automatic random_phase(input int n_items);
		int sent, r, last, j, t;
		int order [8];
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				last = cur_dims - 1;
				for (int i = 0; i < 8; i++) order[i] = i;
				// scramble the leading elements now and then; the last one still closes
				if ($urandom_range(0, 4) == 0) begin
					for (int i = last - 1; i > 0; i--) begin
						j = $urandom_range(0, i);
						t = order[i];
						order[i] = order[j];
						order[j] = t;
					end
				end
				// sometimes break the sample off early
				if ($urandom_range(0, 9) == 0) last = $urandom_range(0, last);
				for (int i = 0; i <= last; i++) begin
					send_request(OP_SAMPLE, $urandom_range(0, 7),
						(i == cur_dims - 1) ? i : order[i], pick_value());
					idle_gap(pick_gap());
					sent++;
				end
			end else begin
				if (r < 70)
					send_request(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
						pick_value());
				else if (r < 88)
					send_request(OP_READ, $urandom_range(0, 7), $urandom_range(0, 7),
						pick_value());
				else if (r < 90)
					send_request(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7),
						pick_value());
				else
					send_request(OP_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 7),
						pick_value());
				idle_gap(pick_gap());
				sent++;
			end
		end
	endtask

	int phase_means [8] = '{8, 3, 1, 0, 15, 2, 8, 5};
	int phase_dims [8] = '{8, 5, 1, 0, 15, 8, 1, 3};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole centroid table so no later search touches an unwritten entry.
		for (int c = 0; c < 8; c++)
			for (int e = 0; e < 8; e++)
				send_request(OP_LOAD, c, e, pick_value());

		// Full sample with the field extremes among its values; it also fills every sample slot.
		send_request(OP_SAMPLE, 0, 0, 16'h8000);
		send_request(OP_SAMPLE, 7, 1, 16'h7FFF);
		send_request(OP_SAMPLE, 0, 2, 16'h0000);
		send_request(OP_SAMPLE, 0, 3, 16'hFFFF);
		send_request(OP_SAMPLE, 0, 4, 16'h0001);
		send_request(OP_SAMPLE, 0, 5, 16'h8000);
		send_request(OP_SAMPLE, 0, 6, 16'h7FFF);
		send_request(OP_SAMPLE, 0, 7, 16'h5555);
		send_request(OP_READ, 0, 0, 16'h0000);
		send_request(OP_READ, 7, 7, 16'hFFFF);

		// Two equal centroids: the lower index must win the tie.
		write_setting(2, 1);
		send_request(OP_LOAD, 0, 0, 16'h0005);
		send_request(OP_LOAD, 1, 0, 16'h0005);
		send_request(OP_SAMPLE, 0, 0, 16'h0005);
		// out-of-range load, sample element and read
		send_request(OP_LOAD, 2, 0, 16'h1234);
		send_request(OP_LOAD, 0, 1, 16'h1234);
		send_request(OP_SAMPLE, 0, 3, 16'h1234);
		send_request(OP_READ, 4, 0, 16'h0000);
		// clear, then a read of the now empty cluster
		send_request(OP_CLEAR, 0, 0, 16'h0000);
		send_request(OP_READ, 0, 0, 16'h0000);
		send_request(OP_SAMPLE, 0, 0, 16'hFFFC);
		send_request(OP_READ, 0, 0, 16'h0000);

		for (int p = 0; p < 8; p++) begin
			write_setting(phase_means[p], phase_dims[p]);
			random_phase(195);
		end

		drain_block();
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
